### rtl/core/mt19937_seed_to_packed_top_bits_macros.svh
// ----------------------------------------------------------------------------
// MT19937 seed-to-code assertion macros
// Immediate-implication and next-cycle-implication checks, removed for synthesis.
// ----------------------------------------------------------------------------
`ifndef MT19937_SEED_TO_PACKED_TOP_BITS_MACROS_SVH
`define MT19937_SEED_TO_PACKED_TOP_BITS_MACROS_SVH

`ifndef SYNTHESIS
`define MTSPTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("mtsptb assertion failed");
`define MTSPTB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("mtsptb assertion failed");
`else
`define MTSPTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define MTSPTB_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/mtsptb_pkg.sv
// ----------------------------------------------------------------------------
// mtsptb_pkg
// Constants, codes and the tempering function of the MT19937 seed-to-code block.
// ----------------------------------------------------------------------------
package mtsptb_pkg;

  localparam int MAX_OFFSET_DEF = 16;
  localparam int MT_SHIFT       = 397;
  localparam int NUM_WORDS      = 6;
  localparam int TOP_BITS       = 5;
  localparam int CODE_W         = NUM_WORDS * TOP_BITS;
  localparam int OFFSET_W       = 5;

  localparam logic [31:0] MT_INIT_MUL = 32'd1812433253;
  localparam logic [31:0] MT_TWIST_A  = 32'h9908_B0DF;
  localparam logic [31:0] TEMPER_B    = 32'h9D2C_5680;
  localparam logic [31:0] TEMPER_C    = 32'hEFC6_0000;
  localparam logic [63:0] LCG_MUL     = 64'h5D58_8B65_6C07_8965;
  localparam logic [63:0] LCG_ADD     = 64'h0000_0000_0026_9EC3;

  typedef enum logic [1:0] {
    OP_LOW     = 2'd0,
    OP_HIGH    = 2'd1,
    OP_LCG     = 2'd2,
    OP_LOW_ALT = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LCG0,
    ST_LCG1,
    ST_LCG2,
    ST_INIT,
    ST_RD0,
    ST_RD1,
    ST_TW
  } state_t;

  function automatic logic [31:0] temper(input logic [31:0] y_in);
    logic [31:0] y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

endpackage

### rtl/core/mt19937_seed_to_packed_top_bits.sv
// ----------------------------------------------------------------------------
// MT19937 seed to packed top bits
// Seeds an MT19937 state in on-chip memory and packs six tempered top fields.
// ----------------------------------------------------------------------------
// One item at a time. An item accepted on start (busy low) runs the states
// LCG0, LCG1, LCG2 (LCG seed form only), INIT up to index offset + 402,
// where offset is start_offset saturated to MAX_OFFSET, then RD0, RD1, TW;
// the next item can be taken in the cycle the result is shown. The
// initialisation recurrence makes one state word per cycle through the
// single shared 32x32 multiplier, written into the state memory. The result
// appears on out_packed_code for exactly one cycle with out_valid and cannot
// be held off, so capture it then. Write start_offset only while busy is low.
`include "mt19937_seed_to_packed_top_bits_macros.svh"

module mt19937_seed_to_packed_top_bits #(
  parameter int MAX_OFFSET = mtsptb_pkg::MAX_OFFSET_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      in_op,
  input  logic [63:0]                     in_seed,
  output logic                            out_valid,
  output logic [mtsptb_pkg::CODE_W-1:0]   out_packed_code,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mtsptb_pkg::OFFSET_W-1:0] cfg_data
);

  localparam int Depth = MAX_OFFSET + mtsptb_pkg::NUM_WORDS + mtsptb_pkg::MT_SHIFT;
  localparam int AW    = $clog2(Depth);

  mtsptb_pkg::state_t state_r, state_nxt;

  logic [mtsptb_pkg::OFFSET_W-1:0] start_offset_r;
  logic [63:0]                     seed_r, seed_nxt;
  logic [31:0]                     prev_r, prev_nxt;
  logic [31:0]                     acc_r, acc_nxt;
  logic [31:0]                     hold_r, hold_nxt;
  logic [AW-1:0]                   idx_r, idx_nxt;
  logic [2:0]                      k_r, k_nxt;
  logic [mtsptb_pkg::CODE_W-1:0]   code_r, code_nxt;
  logic                            out_valid_r, out_valid_nxt;

  logic [31:0] mem [Depth];
  logic [31:0] rda_r, rdb_r;

  logic          accept;
  logic [AW-1:0] off_sat;
  logic [AW-1:0] last_idx;
  logic [31:0]   mul_a, mul_b;
  logic [63:0]   mul_p;
  logic [63:0]   lcg_sum;
  logic [31:0]   wval;
  logic          mem_we, re_a, re_b;
  logic [AW-1:0] rd_addr_a, rd_addr_b;
  logic [31:0]   tw_x, tw_xa, tw_t;
  logic [mtsptb_pkg::TOP_BITS-1:0] tw_v;
  logic          k_last;

  assign busy            = (state_r != mtsptb_pkg::ST_IDLE);
  assign accept          = start && !busy;
  assign cfg_ready       = !busy;
  assign out_valid       = out_valid_r;
  assign out_packed_code = code_r;

  assign off_sat  = (AW'(start_offset_r) > AW'(MAX_OFFSET)) ? AW'(MAX_OFFSET)
                                                             : AW'(start_offset_r);
  assign last_idx = off_sat + AW'(mtsptb_pkg::MT_SHIFT + mtsptb_pkg::NUM_WORDS - 1);
  assign k_last   = (k_r == 3'(mtsptb_pkg::NUM_WORDS - 1));

  // shared multiplier
  always_comb begin
    unique case (state_r)
      mtsptb_pkg::ST_LCG0: begin
        mul_a = seed_r[31:0];
        mul_b = mtsptb_pkg::LCG_MUL[31:0];
      end
      mtsptb_pkg::ST_LCG1: begin
        mul_a = seed_r[31:0];
        mul_b = mtsptb_pkg::LCG_MUL[63:32];
      end
      mtsptb_pkg::ST_LCG2: begin
        mul_a = seed_r[63:32];
        mul_b = mtsptb_pkg::LCG_MUL[31:0];
      end
      default: begin
        mul_a = prev_r ^ (prev_r >> 30);
        mul_b = mtsptb_pkg::MT_INIT_MUL;
      end
    endcase
  end

  assign mul_p   = 64'(mul_a) * 64'(mul_b);
  assign lcg_sum = mul_p + mtsptb_pkg::LCG_ADD;
  assign wval    = (idx_r == '0) ? prev_r : (mul_p[31:0] + 32'(idx_r));

  // twist and temper
  assign tw_x  = {hold_r[31], rda_r[30:0]};
  assign tw_xa = (tw_x >> 1) ^ (tw_x[0] ? mtsptb_pkg::MT_TWIST_A : 32'd0);
  assign tw_t  = mtsptb_pkg::temper(rdb_r ^ tw_xa);
  assign tw_v  = tw_t[31:32-mtsptb_pkg::TOP_BITS];

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mtsptb_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = (mtsptb_pkg::op_t'(in_op) == mtsptb_pkg::OP_LCG) ?
                      mtsptb_pkg::ST_LCG0 : mtsptb_pkg::ST_INIT;
        end
      end
      mtsptb_pkg::ST_LCG0: state_nxt = mtsptb_pkg::ST_LCG1;
      mtsptb_pkg::ST_LCG1: state_nxt = mtsptb_pkg::ST_LCG2;
      mtsptb_pkg::ST_LCG2: state_nxt = mtsptb_pkg::ST_INIT;
      mtsptb_pkg::ST_INIT: begin
        if (idx_r == last_idx) state_nxt = mtsptb_pkg::ST_RD0;
      end
      mtsptb_pkg::ST_RD0: state_nxt = mtsptb_pkg::ST_RD1;
      mtsptb_pkg::ST_RD1: state_nxt = mtsptb_pkg::ST_TW;
      mtsptb_pkg::ST_TW: begin
        if (k_last) state_nxt = mtsptb_pkg::ST_IDLE;
      end
      default: state_nxt = mtsptb_pkg::ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    seed_nxt      = seed_r;
    prev_nxt      = prev_r;
    acc_nxt       = acc_r;
    hold_nxt      = hold_r;
    idx_nxt       = idx_r;
    k_nxt         = k_r;
    code_nxt      = code_r;
    out_valid_nxt = 1'b0;
    mem_we        = 1'b0;
    re_a          = 1'b0;
    re_b          = 1'b0;
    rd_addr_a     = idx_r;
    rd_addr_b     = idx_r + AW'(mtsptb_pkg::MT_SHIFT - 1);
    unique case (state_r)
      mtsptb_pkg::ST_IDLE: begin
        if (accept) begin
          seed_nxt = in_seed;
          idx_nxt  = '0;
          unique case (mtsptb_pkg::op_t'(in_op))
            mtsptb_pkg::OP_HIGH: prev_nxt = in_seed[63:32];
            mtsptb_pkg::OP_LOW, mtsptb_pkg::OP_LCG,
            mtsptb_pkg::OP_LOW_ALT: prev_nxt = in_seed[31:0];
            default: prev_nxt = in_seed[31:0];
          endcase
        end
      end
      mtsptb_pkg::ST_LCG0: acc_nxt  = lcg_sum[63:32];
      mtsptb_pkg::ST_LCG1: acc_nxt  = acc_r + mul_p[31:0];
      mtsptb_pkg::ST_LCG2: prev_nxt = acc_r + mul_p[31:0];
      mtsptb_pkg::ST_INIT: begin
        mem_we   = 1'b1;
        prev_nxt = wval;
        if (idx_r != last_idx) idx_nxt = idx_r + AW'(1);
      end
      mtsptb_pkg::ST_RD0: begin
        re_a      = 1'b1;
        rd_addr_a = off_sat;
        idx_nxt   = off_sat + AW'(1);
      end
      mtsptb_pkg::ST_RD1: begin
        re_a     = 1'b1;
        re_b     = 1'b1;
        hold_nxt = rda_r;
        idx_nxt  = idx_r + AW'(1);
        k_nxt    = '0;
      end
      mtsptb_pkg::ST_TW: begin
        re_a     = !k_last;
        re_b     = !k_last;
        hold_nxt = rda_r;
        idx_nxt  = idx_r + AW'(1);
        k_nxt    = k_r + 3'd1;
        code_nxt = {code_r[mtsptb_pkg::CODE_W-mtsptb_pkg::TOP_BITS-1:0], tw_v};
        out_valid_nxt = k_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= mtsptb_pkg::ST_IDLE;
      start_offset_r <= '0;
      out_valid_r    <= 1'b0;
      k_r            <= '0;
      idx_r          <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      k_r         <= k_nxt;
      idx_r       <= idx_nxt;
      if (cfg_valid && cfg_ready) start_offset_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    seed_r <= seed_nxt;
    prev_r <= prev_nxt;
    acc_r  <= acc_nxt;
    hold_r <= hold_nxt;
    code_r <= code_nxt;
  end

  // state memory
  always_ff @(posedge clk) begin
    if (mem_we) mem[idx_r] <= wval;
    if (re_a) rda_r <= mem[rd_addr_a];
    if (re_b) rdb_r <= mem[rd_addr_b];
  end

  `MTSPTB_ASSERT_NXT(a_accept_busy, clk, rst_n, accept, busy)
  `MTSPTB_ASSERT_NXT(a_done_strobe, clk, rst_n, (state_r == mtsptb_pkg::ST_TW) && k_last, out_valid_r && !busy)
  `MTSPTB_ASSERT_NXT(a_single_strobe, clk, rst_n, out_valid_r, !out_valid_r)
  `MTSPTB_ASSERT_IMP(a_init_bound, clk, rst_n, state_r == mtsptb_pkg::ST_INIT, idx_r <= last_idx)

endmodule

### tb/sv/mt19937_seed_to_packed_top_bits_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MT19937 seed-to-code testbench
// Drives seeds in every seed form through the block under several start
// offsets and checks each packed code against a local recomputation of the
// MT19937 seeding, twist and tempering.
// ----------------------------------------------------------------------------
module mt19937_seed_to_packed_top_bits_tb;

  localparam int CodeW = mtsptb_pkg::CODE_W;
  localparam int OffW  = mtsptb_pkg::OFFSET_W;
  localparam int TopW  = mtsptb_pkg::TOP_BITS;
  localparam int STATE_WORDS = mtsptb_pkg::MAX_OFFSET_DEF + mtsptb_pkg::NUM_WORDS +
                               mtsptb_pkg::MT_SHIFT;

  typedef struct {
    mtsptb_pkg::op_t  op;
    logic [63:0]      seed;
    logic [CodeW-1:0] code;
  } seed_code_t;

  class mt_code_board;
    seed_code_t          pending_codes[$];
    logic [OffW-1:0]     offset;
    int                  errors;

    function new();
      offset = '0;
      errors = 0;
    endfunction

    function logic [CodeW-1:0] packed_code_of(mtsptb_pkg::op_t op, logic [63:0] seed);
      logic [31:0]      st [0:STATE_WORDS-1];
      logic [63:0]      lcg;
      logic [31:0]      x, y, idx;
      logic [CodeW-1:0] code;
      int               eff, last;
      lcg = seed * mtsptb_pkg::LCG_MUL + mtsptb_pkg::LCG_ADD;
      case (op)
        mtsptb_pkg::OP_HIGH: st[0] = seed[63:32];
        mtsptb_pkg::OP_LCG:  st[0] = lcg[63:32];
        default:             st[0] = seed[31:0];
      endcase
      eff  = (offset > mtsptb_pkg::MAX_OFFSET_DEF) ? mtsptb_pkg::MAX_OFFSET_DEF
                                                   : int'(offset);
      last = eff + mtsptb_pkg::NUM_WORDS + mtsptb_pkg::MT_SHIFT;
      for (int i = 1; i < last; i++) begin
        idx   = 32'(i);
        st[i] = mtsptb_pkg::MT_INIT_MUL * (st[i-1] ^ (st[i-1] >> 30)) + idx;
      end
      code = '0;
      for (int k = 0; k < mtsptb_pkg::NUM_WORDS; k++) begin
        x = {st[eff+k][31], st[eff+k+1][30:0]};
        y = st[eff+k+mtsptb_pkg::MT_SHIFT] ^
            ((x >> 1) ^ (x[0] ? mtsptb_pkg::MT_TWIST_A : 32'd0));
        y = y ^ (y >> 11);
        y = y ^ ((y << 7) & mtsptb_pkg::TEMPER_B);
        y = y ^ ((y << 15) & mtsptb_pkg::TEMPER_C);
        y = y ^ (y >> 18);
        code[CodeW-1-TopW*k -: TopW] = y[31:32-TopW];
      end
      return code;
    endfunction

    function void note_seed(mtsptb_pkg::op_t op, logic [63:0] seed);
      seed_code_t e;
      e.op   = op;
      e.seed = seed;
      e.code = packed_code_of(op, seed);
      pending_codes.push_back(e);
    endfunction

    function void check_code(logic [CodeW-1:0] got);
      seed_code_t e;
      if (pending_codes.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("%0t: unexpected code %h with nothing outstanding", $realtime, got);
        return;
      end
      e = pending_codes.pop_front();
      if (got !== e.code) begin
        errors++;
        if (errors <= 10)
          $display("%0t: code mismatch op %0d seed %h offset %0d: expected %h got %h",
                   $realtime, e.op, e.seed, offset, e.code, got);
      end
    endfunction

    function int pending();
      return pending_codes.size();
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [1:0]        in_op;
  logic [63:0]       in_seed;
  logic              out_valid;
  logic [CodeW-1:0]  out_packed_code;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [OffW-1:0]   cfg_data;

  mt_code_board board;

  mt19937_seed_to_packed_top_bits uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_op           (in_op),
    .in_seed         (in_seed),
    .out_valid       (out_valid),
    .out_packed_code (out_packed_code),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      board.check_code(out_packed_code);
  end

  function automatic logic [63:0] pick_seed();
    case ($urandom_range(0, 9))
      0:       return 64'd0;
      1:       return '1;
      2:       return 64'd1 << $urandom_range(0, 63);
      3:       return {$urandom, 32'd0};
      4:       return {32'd0, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 80) return $urandom_range(1, 4);
    if (r < 95) return $urandom_range(5, 50);
    return $urandom_range(51, 450);
  endfunction

  task automatic send_seed(mtsptb_pkg::op_t op, logic [63:0] seed);
    @(negedge clk);
    start   = 1'b1;
    in_op   = op;
    in_seed = seed;
    do @(posedge clk); while (busy);
    board.note_seed(op, seed);
  endtask

  task automatic hold_off(int n);
    repeat (n) begin
      @(negedge clk);
      start   = 1'b0;
      in_op   = 2'($urandom_range(0, 3));
      in_seed = {$urandom, $urandom};
    end
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (board.pending() > 0) @(posedge clk);
  endtask

  task automatic write_offset(logic [OffW-1:0] v);
    drain();
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk); while (!cfg_ready);
    board.offset = v;
    @(negedge clk);
    cfg_valid = 1'b0;
    cfg_data  = OffW'($urandom);
  endtask

  initial begin
    #20_000_000;
    $display("** mt19937_seed_to_packed_top_bits: FAILED **");
    $finish;
  end

  initial begin
    logic [OffW-1:0] phase_offset [5];
    bit              quiet;
    board     = new();
    clk       = 1'b0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_op     = mtsptb_pkg::OP_LOW;
    in_seed   = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // reset offset of zero, every seed form, with extremes for low, high and LCG
    send_seed(mtsptb_pkg::OP_LOW, 64'd0);
    send_seed(mtsptb_pkg::OP_LOW, '1);
    send_seed(mtsptb_pkg::OP_HIGH, 64'd0);
    send_seed(mtsptb_pkg::OP_HIGH, '1);
    send_seed(mtsptb_pkg::OP_LCG, 64'd0);
    send_seed(mtsptb_pkg::OP_LCG, '1);
    send_seed(mtsptb_pkg::OP_LOW_ALT, 64'h0123_4567_89AB_CDEF);
    send_seed(mtsptb_pkg::OP_LOW, 64'h0123_4567_89AB_CDEF);
    send_seed(mtsptb_pkg::OP_HIGH, 64'h8000_0000_0000_0001);
    send_seed(mtsptb_pkg::OP_LCG, 64'hFFFF_FFFF_0000_0000);
    write_offset(5'd16);
    send_seed(mtsptb_pkg::OP_LOW, 64'd5489);
    send_seed(mtsptb_pkg::OP_LCG, 64'h0000_0000_FFFF_FFFF);
    send_seed(mtsptb_pkg::OP_LOW_ALT, '1);
    // offsets beyond the bound saturate
    write_offset(5'd31);
    send_seed(mtsptb_pkg::OP_LOW, 64'd5489);
    send_seed(mtsptb_pkg::OP_HIGH, 64'h1234_5678_0000_0000);
    send_seed(mtsptb_pkg::OP_LCG, {$urandom, $urandom});
    write_offset(5'd17);
    send_seed(mtsptb_pkg::OP_LOW_ALT, 64'd0);
    write_offset(5'd1);
    send_seed(mtsptb_pkg::OP_HIGH, 64'hDEAD_BEEF_CAFE_F00D);

    phase_offset[0] = 5'd0;
    phase_offset[1] = 5'd16;
    phase_offset[2] = OffW'($urandom_range(0, 31));
    phase_offset[3] = 5'd31;
    phase_offset[4] = OffW'($urandom_range(1, 15));
    quiet = 1'b0;
    for (int ph = 0; ph < 5; ph++) begin
      write_offset(phase_offset[ph]);
      for (int n = 0; n < 250; n++) begin
        if (n % 50 == 0)
          quiet = ($urandom_range(0, 3) == 0);
        send_seed(mtsptb_pkg::op_t'($urandom_range(0, 3)), pick_seed());
        if (!quiet)
          hold_off(pick_gap());
        if ($urandom_range(0, 99) == 0)
          drain();
      end
    end

    drain();
    repeat (450) @(posedge clk);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("** mt19937_seed_to_packed_top_bits: PASSED **");
    end else begin
      $display("** mt19937_seed_to_packed_top_bits: FAILED **");
    end
    $finish;
  end

endmodule
